>>> src/saturating_signed_alu_64_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the saturating signed ALU
// Shared property forms for the port checker, clocked on clk with rst_n.
// ----------------------------------------------------------------------------
`ifndef SATURATING_SIGNED_ALU_64_ASSERT_SVH
`define SATURATING_SIGNED_ALU_64_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define SSALU_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define SSALU_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> src/ssalu64_pkg.sv
// ----------------------------------------------------------------------------
// ssalu64_pkg
// Shared types and constants of the saturating signed ALU.
// ----------------------------------------------------------------------------
package ssalu64_pkg;

    // Default datapath width.
    localparam int DataWidthDef = 64;

    // Action codes carried by each item.
    typedef enum logic [2:0] {
        ActAdd    = 3'd0,
        ActSub    = 3'd1,
        ActMul    = 3'd2,
        ActDiv    = 3'd3,
        ActRem    = 3'd4,
        ActShl    = 3'd5,
        ActShr    = 3'd6,
        ActCmp    = 3'd7
    } action_t;

    // Compare outcome codes.
    localparam logic [1:0] OrdLess    = 2'd0;
    localparam logic [1:0] OrdEqual   = 2'd1;
    localparam logic [1:0] OrdGreater = 2'd2;

endpackage

>>> src/saturating_signed_alu_64.sv
// ----------------------------------------------------------------------------
// saturating_signed_alu_64
// Saturating signed ALU with an iterative multiply and divide unit.
// ----------------------------------------------------------------------------
// The block takes one item at a time and returns one result for it. Add,
// subtract, shifts and compare form their result in the setup state, and the
// finish state loads it into the output register. Multiply, divide and
// remainder pass through a setup step, DATA_WIDTH passes through the shared
// adder that handles one multiplier or quotient bit per cycle, a sign fixup
// step and a step that loads the output register. Division or remainder by
// zero skips the loop and the fixup. The next item is taken once the current
// result has moved into the output register, so a waiting result does not
// block the input side.
// ----------------------------------------------------------------------------
module saturating_signed_alu_64 #(
    parameter int DATA_WIDTH = ssalu64_pkg::DataWidthDef
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               item_valid,
    output logic               item_ready,
    input  logic [2:0]         action,
    input  logic signed [63:0] operand_a,
    input  logic signed [63:0] operand_b,
    input  logic [5:0]         shift_amount,
    output logic               result_valid,
    input  logic               result_ready,
    output logic signed [63:0] result_value,
    output logic               saturated,
    output logic               divide_by_zero,
    output logic [1:0]         order
);

    localparam int W  = DATA_WIDTH;
    localparam int CW = $clog2(DATA_WIDTH);
    localparam logic signed [W-1:0] SMax = {1'b0, {(W-1){1'b1}}};
    localparam logic signed [W-1:0] SMin = {1'b1, {(W-1){1'b0}}};

    typedef enum logic [2:0] {
        S_IDLE,
        S_SETUP,
        S_LOOP,
        S_FIXUP,
        S_FINISH
    } state_t;

    // Negation that maps the minimum onto the maximum.
    function automatic logic signed [W-1:0] sneg_sat(input logic signed [W-1:0] x);
        logic signed [W-1:0] r;
        begin
            r = (x == SMin) ? SMax : -x;
            return r;
        end
    endfunction

    state_t                   state_reg, state_next;
    ssalu64_pkg::action_t     act_reg, act_next;
    logic signed [W-1:0]      a_reg, a_next;
    logic signed [W-1:0]      b_reg, b_next;
    logic [5:0]               sh_reg, sh_next;
    logic                     neg_reg, neg_next;
    logic [W-1:0]             acc_reg, acc_next;
    logic [W-1:0]             lo_reg, lo_next;
    logic [W-1:0]             mag_reg, mag_next;
    logic [CW-1:0]            cnt_reg, cnt_next;
    logic signed [W-1:0]      res_reg, res_next;
    logic                     sat_reg, sat_next;
    logic                     dbz_reg, dbz_next;
    logic [1:0]               ord_reg, ord_next;
    logic                     out_valid_reg, out_valid_next;
    logic signed [63:0]       out_value_reg, out_value_next;
    logic                     out_sat_reg, out_sat_next;
    logic                     out_dbz_reg, out_dbz_next;
    logic [1:0]               out_ord_reg, out_ord_next;

    // Shared adder and setup values.
    logic [W+1:0]             au_x, au_y, au_sum;
    logic                     au_sub;
    logic                     ge;
    logic [W-1:0]             ma, mb;
    logic [W-1:0]             add_sum, sub_dif;
    logic signed [W-1:0]      shift_src, shift_val;
    logic signed [W-1:0]      neg_lo, neg_acc;
    logic                     mul_over;

    assign item_ready     = (state_reg == S_IDLE);
    assign result_valid   = out_valid_reg;
    assign result_value   = out_value_reg;
    assign saturated      = out_sat_reg;
    assign divide_by_zero = out_dbz_reg;
    assign order          = out_ord_reg;

    // Operand muxing for the shared adder: shift-add for multiply,
    // restoring subtract for divide and remainder.
    always_comb
    begin
        if (act_reg == ssalu64_pkg::ActMul)
        begin
            au_x   = {2'b00, acc_reg};
            au_y   = {2'b00, (lo_reg[0] ? mag_reg : {W{1'b0}})};
            au_sub = 1'b0;
        end
        else
        begin
            au_x   = {1'b0, acc_reg, lo_reg[W-1]};
            au_y   = {2'b00, mag_reg};
            au_sub = 1'b1;
        end
        au_sum = au_x + (au_sub ? ~au_y : au_y) + (W+2)'(au_sub);
        ge     = ~au_sum[W+1];
    end

    // Setup and fixup helpers.
    always_comb
    begin
        ma        = a_reg[W-1] ? W'(-a_reg) : W'(a_reg);
        mb        = b_reg[W-1] ? W'(-b_reg) : W'(b_reg);
        add_sum   = W'(a_reg) + W'(b_reg);
        sub_dif   = W'(a_reg) - W'(b_reg);
        shift_src = a_reg[W-1] ? sneg_sat(a_reg) : a_reg;
        if (act_reg == ssalu64_pkg::ActShl)
        begin
            shift_val = shift_src << sh_reg;
        end
        else
        begin
            shift_val = $signed(W'($unsigned(shift_src) >> sh_reg));
        end
        neg_lo   = -$signed(lo_reg);
        neg_acc  = -$signed(acc_reg);
        mul_over = (|acc_reg) ||
                   (neg_reg ? (lo_reg[W-1] && (|lo_reg[W-2:0])) : lo_reg[W-1]);
    end

    // Sequencer next-state logic.
    always_comb
    begin
        state_next     = state_reg;
        act_next       = act_reg;
        a_next         = a_reg;
        b_next         = b_reg;
        sh_next        = sh_reg;
        neg_next       = neg_reg;
        acc_next       = acc_reg;
        lo_next        = lo_reg;
        mag_next       = mag_reg;
        cnt_next       = cnt_reg;
        res_next       = res_reg;
        sat_next       = sat_reg;
        dbz_next       = dbz_reg;
        ord_next       = ord_reg;
        out_valid_next = out_valid_reg;
        out_value_next = out_value_reg;
        out_sat_next   = out_sat_reg;
        out_dbz_next   = out_dbz_reg;
        out_ord_next   = out_ord_reg;

        if (out_valid_reg && result_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (item_valid)
                begin
                    act_next   = ssalu64_pkg::action_t'(action);
                    a_next     = $signed(operand_a[W-1:0]);
                    b_next     = $signed(operand_b[W-1:0]);
                    sh_next    = shift_amount;
                    state_next = S_SETUP;
                end
            end
            S_SETUP:
            begin
                res_next   = '0;
                sat_next   = 1'b0;
                dbz_next   = 1'b0;
                ord_next   = ssalu64_pkg::OrdLess;
                neg_next   = a_reg[W-1] ^ b_reg[W-1];
                acc_next   = '0;
                cnt_next   = CW'(W - 1);
                state_next = S_FINISH;
                case (act_reg)
                    ssalu64_pkg::ActAdd:
                    begin
                        if ((a_reg[W-1] == b_reg[W-1]) && (add_sum[W-1] != a_reg[W-1]))
                        begin
                            res_next = a_reg[W-1] ? SMin : SMax;
                            sat_next = 1'b1;
                        end
                        else
                        begin
                            res_next = $signed(add_sum);
                        end
                    end
                    ssalu64_pkg::ActSub:
                    begin
                        if ((a_reg[W-1] != b_reg[W-1]) && (sub_dif[W-1] != a_reg[W-1]))
                        begin
                            res_next = a_reg[W-1] ? SMin : SMax;
                            sat_next = 1'b1;
                        end
                        else
                        begin
                            res_next = $signed(sub_dif);
                        end
                    end
                    ssalu64_pkg::ActMul:
                    begin
                        lo_next    = mb;
                        mag_next   = ma;
                        state_next = S_LOOP;
                    end
                    ssalu64_pkg::ActDiv,
                    ssalu64_pkg::ActRem:
                    begin
                        if (b_reg == '0)
                        begin
                            dbz_next = 1'b1;
                            if (act_reg == ssalu64_pkg::ActDiv)
                            begin
                                res_next = a_reg[W-1] ? SMin : SMax;
                                sat_next = 1'b1;
                            end
                            else
                            begin
                                res_next = a_reg;
                            end
                        end
                        else
                        begin
                            lo_next    = ma;
                            mag_next   = mb;
                            state_next = S_LOOP;
                        end
                    end
                    ssalu64_pkg::ActShl,
                    ssalu64_pkg::ActShr:
                    begin
                        res_next = a_reg[W-1] ? sneg_sat(shift_val) : shift_val;
                    end
                    ssalu64_pkg::ActCmp:
                    begin
                        if (a_reg < b_reg)
                        begin
                            ord_next = ssalu64_pkg::OrdLess;
                        end
                        else if (a_reg == b_reg)
                        begin
                            ord_next = ssalu64_pkg::OrdEqual;
                        end
                        else
                        begin
                            ord_next = ssalu64_pkg::OrdGreater;
                        end
                    end
                    default:
                    begin
                        res_next = '0;
                    end
                endcase
            end
            S_LOOP:
            begin
                // One multiplier bit or one quotient bit per cycle.
                if (act_reg == ssalu64_pkg::ActMul)
                begin
                    acc_next = au_sum[W:1];
                    lo_next  = {au_sum[0], lo_reg[W-1:1]};
                end
                else
                begin
                    acc_next = ge ? au_sum[W-1:0] : {acc_reg[W-2:0], lo_reg[W-1]};
                    lo_next  = {lo_reg[W-2:0], ge};
                end
                if (cnt_reg == '0)
                begin
                    state_next = S_FIXUP;
                end
                else
                begin
                    cnt_next = cnt_reg - 1'b1;
                end
            end
            S_FIXUP:
            begin
                // Apply signs and clamp the magnitude results.
                state_next = S_FINISH;
                case (act_reg)
                    ssalu64_pkg::ActMul:
                    begin
                        if (mul_over)
                        begin
                            res_next = neg_reg ? SMin : SMax;
                            sat_next = 1'b1;
                        end
                        else
                        begin
                            res_next = neg_reg ? neg_lo : $signed(lo_reg);
                        end
                    end
                    ssalu64_pkg::ActDiv:
                    begin
                        if (!neg_reg && lo_reg[W-1])
                        begin
                            res_next = SMax;
                            sat_next = 1'b1;
                        end
                        else
                        begin
                            res_next = neg_reg ? neg_lo : $signed(lo_reg);
                        end
                    end
                    default:
                    begin
                        res_next = a_reg[W-1] ? neg_acc : $signed(acc_reg);
                    end
                endcase
            end
            S_FINISH:
            begin
                // Move the result into the output register once it is free.
                if (!out_valid_reg || result_ready)
                begin
                    out_valid_next = 1'b1;
                    out_value_next = 64'(res_reg);
                    out_sat_next   = sat_reg;
                    out_dbz_next   = dbz_reg;
                    out_ord_next   = ord_reg;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State and registered outputs.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            act_reg       <= ssalu64_pkg::ActAdd;
            a_reg         <= '0;
            b_reg         <= '0;
            sh_reg        <= '0;
            neg_reg       <= 1'b0;
            acc_reg       <= '0;
            lo_reg        <= '0;
            mag_reg       <= '0;
            cnt_reg       <= '0;
            res_reg       <= '0;
            sat_reg       <= 1'b0;
            dbz_reg       <= 1'b0;
            ord_reg       <= ssalu64_pkg::OrdLess;
            out_valid_reg <= 1'b0;
            out_value_reg <= '0;
            out_sat_reg   <= 1'b0;
            out_dbz_reg   <= 1'b0;
            out_ord_reg   <= ssalu64_pkg::OrdLess;
        end
        else
        begin
            state_reg     <= state_next;
            act_reg       <= act_next;
            a_reg         <= a_next;
            b_reg         <= b_next;
            sh_reg        <= sh_next;
            neg_reg       <= neg_next;
            acc_reg       <= acc_next;
            lo_reg        <= lo_next;
            mag_reg       <= mag_next;
            cnt_reg       <= cnt_next;
            res_reg       <= res_next;
            sat_reg       <= sat_next;
            dbz_reg       <= dbz_next;
            ord_reg       <= ord_next;
            out_valid_reg <= out_valid_next;
            out_value_reg <= out_value_next;
            out_sat_reg   <= out_sat_next;
            out_dbz_reg   <= out_dbz_next;
            out_ord_reg   <= out_ord_next;
        end
    end

endmodule

>>> src/ssalu64_checker.sv
// ----------------------------------------------------------------------------
// ssalu64_checker
// Port-level checks of the saturating signed ALU, bound to the top level.
// ----------------------------------------------------------------------------
`include "saturating_signed_alu_64_assert.svh"

module ssalu64_checker #(
    parameter int DATA_WIDTH = ssalu64_pkg::DataWidthDef
) (
    input logic               clk,
    input logic               rst_n,
    input logic               item_valid,
    input logic               item_ready,
    input logic [2:0]         action,
    input logic signed [63:0] operand_a,
    input logic signed [63:0] operand_b,
    input logic [5:0]         shift_amount,
    input logic               result_valid,
    input logic               result_ready,
    input logic signed [63:0] result_value,
    input logic               saturated,
    input logic               divide_by_zero,
    input logic [1:0]         order
);

    // The block works on one item at a time.
    `SSALU_ASSERT_NEXT(a_one_item, item_valid && item_ready, !item_ready, "ready after accept")

    // A compare outcome comes with a zero result and no flags.
    `SSALU_ASSERT_NOW(a_cmp_clean, result_valid && (order != ssalu64_pkg::OrdLess), (result_value == 64'sd0) && !saturated && !divide_by_zero, "compare result not clean")

    // A clamped result is the signed maximum or minimum of the width.
    `SSALU_ASSERT_NOW(a_sat_limit, result_valid && saturated, result_value[DATA_WIDTH-2:0] == {(DATA_WIDTH-1){~result_value[DATA_WIDTH-1]}}, "saturated result is not a limit")

    // A waiting result holds until it is taken.
    `SSALU_ASSERT_NEXT(a_out_hold, result_valid && !result_ready, result_valid && $stable(result_value), "result dropped or changed")

endmodule

bind saturating_signed_alu_64 ssalu64_checker #(.DATA_WIDTH(DATA_WIDTH)) u_ssalu64_checker (.*);
